// ===== rtl/core/pssc_pkg.sv =====
package pssc_pkg;

   localparam int THREADS     = 16;
   localparam int STACK_DEPTH = 64;

   localparam int TID_W  = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int PTR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = 64;
   localparam int RAM_DEPTH = THREADS * STACK_DEPTH;
   localparam int RAM_AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

   // event codes
   localparam logic [2:0] EV_OK        = 3'd0;
   localparam logic [2:0] EV_DEEPER    = 3'd1;
   localparam logic [2:0] EV_NOT_FOUND = 3'd2;
   localparam logic [2:0] EV_OVERWRITE = 3'd3;
   localparam logic [2:0] EV_PUSH_POP  = 3'd4;
   localparam logic [2:0] EV_OVERFLOW  = 3'd5;
   localparam logic [2:0] EV_EMPTY     = 3'd6;

   // input event kinds
   localparam logic [1:0] FN_CALL   = 2'd0;
   localparam logic [1:0] FN_RET    = 2'd1;
   localparam logic [1:0] FN_WRITE  = 2'd2;
   localparam logic [1:0] FN_UNUSED = 2'd3;

   // classified operations
   localparam logic [2:0] OP_CALL     = 3'd0;
   localparam logic [2:0] OP_RET_POP  = 3'd1;
   localparam logic [2:0] OP_RET_SRCH = 3'd2;
   localparam logic [2:0] OP_WR_SRCH  = 3'd3;
   localparam logic [2:0] OP_NOP      = 3'd4;

   typedef struct packed {
      logic [2:0]        op;
      logic [TID_W-1:0]  tid;
      logic [ADDR_W-1:0] addr;
   } item_type;

endpackage

// ===== rtl/core/per_thread_shadow_stack_checker.sv =====
// Shadow return stack checker, one stack of stack-pointer values per thread,
// held as a ring in a single memory so an overflowing call drops the oldest
// entry by moving a head pointer. Each event gives one result. A call, a
// return directly after a push, and any event on an empty stack finish in
// idle in the back end. A plain return or a memory write searches the
// thread's stack from the top, one memory read a cycle, until a hit or
// the bottom (a full stack holds 64 entries). A two-item queue in front
// lets new items arrive while a search runs, and a result register lets
// the next item start as soon as a waiting result is taken.
module per_thread_shadow_stack_checker
   import pssc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_func,
   input  logic [3:0]        req_thread_id,
   input  logic [ADDR_W-1:0] req_address,
   input  logic              req_after_push,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_event_code,
   output logic [6:0]        rsp_entries_removed,
   output logic [6:0]        rsp_depth_after
);

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   pssc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_thread_id (req_thread_id),
      .req_address   (req_address),
      .req_after_push(req_after_push),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   pssc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_code     (rsp_event_code),
      .rsp_entries_removed(rsp_entries_removed),
      .rsp_depth_after    (rsp_depth_after)
   );

endmodule

// ===== rtl/core/pssc_ram.sv =====
module pssc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pssc_front.sv =====
module pssc_front
   import pssc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_func,
   input  logic [3:0]        req_thread_id,
   input  logic [ADDR_W-1:0] req_address,
   input  logic              req_after_push,
   output logic              q_valid,
   output item_type          q_item,
   input  logic              q_pop
);

   item_type    slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   item_type    cls;
   logic        push;

   // classify the incoming item
   always_comb begin
      cls.tid  = TID_W'(req_thread_id % THREADS);
      cls.addr = req_address;
      unique case (req_func)
         FN_CALL:  cls.op = OP_CALL;
         FN_RET:   cls.op = req_after_push ? OP_RET_POP : OP_RET_SRCH;
         FN_WRITE: cls.op = OP_WR_SRCH;
         default:  cls.op = OP_NOP;
      endcase
   end

   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (fill_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   // two-entry queue pointers
   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ===== rtl/core/pssc_back.sv =====
module pssc_back
   import pssc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  item_type   q_item,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_event_code,
   output logic [6:0] rsp_entries_removed,
   output logic [6:0] rsp_depth_after
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SRCH = 1'b1;

   logic              state_ff, state_in;
   logic [CNT_W-1:0]  count_ff [THREADS];
   logic [PTR_W-1:0]  head_ff  [THREADS];
   logic              cnt_we;
   logic [CNT_W-1:0]  cnt_wdata;
   logic              head_we;
   logic [PTR_W-1:0]  head_wdata;

   item_type          cur_ff, cur_in;
   logic [CNT_W-1:0]  cnt_cur_ff, cnt_cur_in;
   logic [PTR_W-1:0]  head_cur_ff, head_cur_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic [PTR_W-1:0]  rd_i_ff, rd_i_in;
   logic [PTR_W-1:0]  cmp_i_ff, cmp_i_in;
   logic              cmp_v_ff, cmp_v_in;

   logic              out_v_ff, out_v_in;
   logic [2:0]        out_code_ff, out_code_in;
   logic [6:0]        out_rem_ff, out_rem_in;
   logic [6:0]        out_dep_ff, out_dep_in;

   logic              out_free;
   logic [CNT_W-1:0]  q_cnt;
   logic [PTR_W-1:0]  q_head;
   logic              ram_we, ram_re;
   logic [RAM_AW-1:0] ram_waddr, ram_raddr;
   logic [ADDR_W-1:0] ram_q;
   logic [CNT_W-1:0]  cmp_cnt;

   // physical slot of logical entry i in a ring starting at head
   function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                             input logic [PTR_W-1:0] i);
      logic [PTR_W:0] s;
      s = {1'b0, head} + {1'b0, i};
      if (s >= (PTR_W+1)'(STACK_DEPTH)) begin
         s = s - (PTR_W+1)'(STACK_DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

   function automatic logic [RAM_AW-1:0] ram_at(input logic [TID_W-1:0] tid,
                                                input logic [PTR_W-1:0] p);
      return RAM_AW'(tid * STACK_DEPTH + p);
   endfunction

   assign out_free = !out_v_ff || rsp_ready;
   assign q_cnt    = count_ff[q_item.tid];
   assign q_head   = head_ff[q_item.tid];
   assign cmp_cnt  = {{(CNT_W-PTR_W){1'b0}}, cmp_i_ff};

   // sequencer: direct ops in idle, top-down search otherwise
   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      cnt_cur_in  = cnt_cur_ff;
      head_cur_in = head_cur_ff;
      left_in     = left_ff;
      rd_i_in     = rd_i_ff;
      cmp_i_in    = cmp_i_ff;
      cmp_v_in    = cmp_v_ff;
      out_v_in    = out_v_ff && !rsp_ready;
      out_code_in = out_code_ff;
      out_rem_in  = out_rem_ff;
      out_dep_in  = out_dep_ff;
      q_pop       = 1'b0;
      cnt_we      = 1'b0;
      cnt_wdata   = q_cnt;
      head_we     = 1'b0;
      head_wdata  = q_head;
      ram_we      = 1'b0;
      ram_waddr   = ram_at(q_item.tid, phys(q_head, q_cnt[PTR_W-1:0]));
      ram_re      = 1'b0;
      ram_raddr   = ram_at(cur_ff.tid, phys(head_cur_ff, rd_i_ff));

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop       = 1'b1;
               out_code_in = EV_OK;
               out_rem_in  = 7'd0;
               out_dep_in  = 7'(q_cnt);
               cur_in      = q_item;
               cnt_cur_in  = q_cnt;
               head_cur_in = q_head;
               unique case (q_item.op)
                  OP_CALL: begin
                     out_v_in = 1'b1;
                     ram_we   = 1'b1;
                     if (q_cnt == CNT_W'(STACK_DEPTH)) begin
                        ram_waddr   = ram_at(q_item.tid, q_head);
                        head_we     = 1'b1;
                        head_wdata  = phys(q_head, PTR_W'(1));
                        out_code_in = EV_OVERFLOW;
                        out_rem_in  = 7'd1;
                     end else begin
                        cnt_we     = 1'b1;
                        cnt_wdata  = q_cnt + CNT_W'(1);
                        out_dep_in = 7'(q_cnt + CNT_W'(1));
                     end
                  end
                  OP_RET_POP: begin
                     out_v_in = 1'b1;
                     if (q_cnt == '0) begin
                        out_code_in = EV_EMPTY;
                     end else begin
                        cnt_we      = 1'b1;
                        cnt_wdata   = q_cnt - CNT_W'(1);
                        out_code_in = EV_PUSH_POP;
                        out_rem_in  = 7'd1;
                        out_dep_in  = 7'(q_cnt - CNT_W'(1));
                     end
                  end
                  OP_RET_SRCH, OP_WR_SRCH: begin
                     if (q_cnt == '0) begin
                        out_v_in    = 1'b1;
                        out_code_in = (q_item.op == OP_RET_SRCH) ? EV_EMPTY : EV_OK;
                     end else begin
                        state_in = S_SRCH;
                        left_in  = q_cnt;
                        rd_i_in  = PTR_W'(q_cnt - CNT_W'(1));
                        cmp_v_in = 1'b0;
                     end
                  end
                  default: begin
                     out_v_in = 1'b1;
                  end
               endcase
            end
         end
         S_SRCH: begin
            if (cmp_v_ff && ram_q == cur_ff.addr) begin
               // hit at cmp_i
               if (out_free) begin
                  out_v_in = 1'b1;
                  state_in = S_IDLE;
                  if (cur_ff.op == OP_RET_SRCH) begin
                     cnt_we      = 1'b1;
                     cnt_wdata   = cmp_cnt;
                     out_code_in = (cmp_cnt == cnt_cur_ff - CNT_W'(1)) ? EV_OK : EV_DEEPER;
                     out_rem_in  = 7'(cnt_cur_ff - cmp_cnt);
                     out_dep_in  = 7'(cmp_cnt);
                  end else begin
                     out_code_in = EV_OVERWRITE;
                  end
               end
            end else if (left_ff != '0) begin
               ram_re   = 1'b1;
               cmp_i_in = rd_i_ff;
               cmp_v_in = 1'b1;
               rd_i_in  = rd_i_ff - PTR_W'(1);
               left_in  = left_ff - CNT_W'(1);
            end else if (out_free) begin
               // searched every entry without a hit
               out_v_in    = 1'b1;
               state_in    = S_IDLE;
               out_code_in = (cur_ff.op == OP_RET_SRCH) ? EV_NOT_FOUND : EV_OK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, result valid, per-thread counts and ring heads
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
         cmp_v_ff <= 1'b0;
         for (int t = 0; t < THREADS; t++) begin
            count_ff[t] <= '0;
            head_ff[t]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         cmp_v_ff <= cmp_v_in;
         if (cnt_we) begin
            count_ff[(state_ff == S_IDLE) ? q_item.tid : cur_ff.tid] <= cnt_wdata;
         end
         if (head_we) begin
            head_ff[q_item.tid] <= head_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      cnt_cur_ff  <= cnt_cur_in;
      head_cur_ff <= head_cur_in;
      left_ff     <= left_in;
      rd_i_ff     <= rd_i_in;
      cmp_i_ff    <= cmp_i_in;
      out_code_ff <= out_code_in;
      out_rem_ff  <= out_rem_in;
      out_dep_ff  <= out_dep_in;
   end

   pssc_ram #(
      .WIDTH(ADDR_W),
      .DEPTH(RAM_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(q_item.addr),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_q)
   );

   assign rsp_valid           = out_v_ff;
   assign rsp_event_code      = out_code_ff;
   assign rsp_entries_removed = out_rem_ff;
   assign rsp_depth_after     = out_dep_ff;

endmodule

// ===== tb/shadow_stack_monitor.sv =====
`default_nettype none
module shadow_stack_monitor
   import pssc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic [1:0]        req_func,
   input  wire logic [3:0]        req_thread_id,
   input  wire logic [ADDR_W-1:0] req_address,
   input  wire logic              req_after_push,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic [2:0]        rsp_event_code,
   input  wire logic [6:0]        rsp_entries_removed,
   input  wire logic [6:0]        rsp_depth_after,
   output int                     fail_count,
   output int                     pending_count,
   output int                     result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0] code;
      logic [6:0] removed;
      logic [6:0] depth;
   } verdict_type;

   // shadow copy of the per-thread stacks, oldest entry at index 0
   logic [ADDR_W-1:0] shadow_slots [THREADS][STACK_DEPTH];
   int                shadow_depth [THREADS];
   verdict_type       verdict_queue [$];

   assign pending_count = verdict_queue.size();

   function automatic int search_from_top(int t, int n, logic [ADDR_W-1:0] key);
      for (int i = n - 1; i >= 0; i--)
         if (shadow_slots[t][i] == key) return i;
      return -1;
   endfunction

   function automatic verdict_type apply_event(logic [1:0] fn, logic [3:0] tid_in,
                                               logic [ADDR_W-1:0] a, logic ap);
      verdict_type v;
      int t;
      int n;
      int p;
      t = int'(tid_in) % THREADS;
      n = shadow_depth[t];
      v = '0;
      if (fn == FN_CALL) begin
         if (n >= STACK_DEPTH) begin
            for (int i = 0; i < STACK_DEPTH - 1; i++)
               shadow_slots[t][i] = shadow_slots[t][i+1];
            shadow_slots[t][STACK_DEPTH-1] = a;
            v.code = EV_OVERFLOW;
            v.removed = 7'd1;
         end else begin
            shadow_slots[t][n] = a;
            n++;
         end
      end else if (fn == FN_RET) begin
         if (n == 0) begin
            v.code = EV_EMPTY;
         end else if (ap) begin
            n--;
            v.code = EV_PUSH_POP;
            v.removed = 7'd1;
         end else begin
            p = search_from_top(t, n, a);
            if (p < 0) begin
               v.code = EV_NOT_FOUND;
            end else begin
               v.code = (p == n - 1) ? EV_OK : EV_DEEPER;
               v.removed = 7'(n - p);
               n = p;
            end
         end
      end else if (fn == FN_WRITE) begin
         if (search_from_top(t, n, a) >= 0) v.code = EV_OVERWRITE;
      end
      shadow_depth[t] = n;
      v.depth = 7'(n);
      return v;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      fail_count++;
   endtask

   // predict on every accepted item, compare on every accepted result
   always @(posedge clock) begin
      verdict_type w;
      if (reset) begin
         verdict_queue.delete();
         foreach (shadow_depth[i]) shadow_depth[i] = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (verdict_queue.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               w = verdict_queue.pop_front();
               if (rsp_event_code !== w.code)
                  report_mismatch("event_code", rsp_event_code, w.code);
               if (rsp_entries_removed !== w.removed)
                  report_mismatch("entries_removed", rsp_entries_removed, w.removed);
               if (rsp_depth_after !== w.depth)
                  report_mismatch("depth_after", rsp_depth_after, w.depth);
            end
         end
         if (req_valid && req_ready)
            verdict_queue.push_back(apply_event(req_func, req_thread_id,
                                                req_address, req_after_push));
      end
   end

   initial begin
      fail_count = 0;
      result_count = 0;
   end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench
   import pssc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_func = FN_CALL;
   logic [3:0]        req_thread_id = '0;
   logic [ADDR_W-1:0] req_address = '0;
   logic              req_after_push = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [2:0]        rsp_event_code;
   logic [6:0]        rsp_entries_removed;
   logic [6:0]        rsp_depth_after;
   int                fail_count;
   int                pending_count;
   int                result_count;
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   int                sent_count = 0;

   // pool of stack pointers per thread so returns and writes often hit
   logic [ADDR_W-1:0] recent_sp [16][$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   per_thread_shadow_stack_checker dut (.*);

   shadow_stack_monitor monitor (.*);

   // receiver stalls at random
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   task automatic send_item(logic [1:0] fn, logic [3:0] tid, logic [ADDR_W-1:0] a,
                            logic ap);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= fn;
      req_thread_id <= tid;
      req_address <= a;
      req_after_push <= ap;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      if (fn == FN_CALL) begin
         recent_sp[tid].push_back(a);
         if (recent_sp[tid].size() > 80) void'(recent_sp[tid].pop_front());
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic [ADDR_W-1:0] pick_address(logic [3:0] tid);
      if (recent_sp[tid].size() != 0 && $urandom_range(99) < 75)
         return recent_sp[tid][$urandom_range(recent_sp[tid].size() - 1)];
      return {$urandom, $urandom};
   endfunction

   task automatic random_phase(int n, int idle, int stall);
      logic [3:0] tid;
      int r;
      send_idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < n; i++) begin
         // few threads mostly, so stacks get deep and overflow
         tid = ($urandom_range(99) < 80) ? 4'($urandom_range(2)) : 4'($urandom);
         r = $urandom_range(99);
         if (r < 45)
            send_item(FN_CALL, tid, {$urandom, $urandom}, 1'b0);
         else if (r < 75)
            send_item(FN_RET, tid, pick_address(tid), ($urandom_range(9) == 0));
         else if (r < 95)
            send_item(FN_WRITE, tid, pick_address(tid), 1'($urandom));
         else
            send_item(FN_UNUSED, tid, {$urandom, $urandom}, 1'($urandom));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty stack, extremes, every event kind
      send_item(FN_RET, 4'd0, '0, 1'b0);
      send_item(FN_RET, 4'd0, '0, 1'b1);
      send_item(FN_WRITE, 4'd15, '1, 1'b0);
      send_item(FN_CALL, 4'd15, '1, 1'b0);
      send_item(FN_CALL, 4'd15, 64'h5555_5555_5555_5555, 1'b0);
      send_item(FN_CALL, 4'd15, '0, 1'b0);
      send_item(FN_WRITE, 4'd15, '1, 1'b0);
      send_item(FN_RET, 4'd15, 64'h1234, 1'b0);
      send_item(FN_RET, 4'd15, '1, 1'b0);
      send_item(FN_CALL, 4'd15, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      send_item(FN_RET, 4'd15, 64'h0, 1'b1);
      send_item(FN_RET, 4'd15, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      send_item(FN_UNUSED, 4'd15, '1, 1'b1);
      // overflow one thread and unwind from the bottom
      for (int i = 0; i < STACK_DEPTH + 3; i++)
         send_item(FN_CALL, 4'd7, 64'(i + 100), 1'b0);
      send_item(FN_WRITE, 4'd7, 64'd100, 1'b0);
      send_item(FN_WRITE, 4'd7, 64'd103, 1'b0);
      send_item(FN_RET, 4'd7, 64'd103, 1'b0);
      // sender holds off until all results are back
      wait_drained();

      random_phase(500, 0, 0);
      random_phase(500, 68, 0);
      wait_drained();
      random_phase(500, 0, 68);
      random_phase(450, 19, 19);
      wait_drained();
      repeat (100) @(posedge clock);

      $display("sent %0d items over all event kinds, empty, overflow and deep returns,",
               sent_count);
      $display("%0d results checked under sender gaps and receiver stalls", result_count);
      if (fail_count == 0 && pending_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // run limit
   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire
